// ===== sv/uqsd_pkg.sv =====
// Package with the types, character codes and hex decode of the query string decoder.
package uqsd_pkg;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_KEY    = 5'b00010,
    PH_VALUE  = 5'b00100,
    PH_KEYESC = 5'b01000,
    PH_VALESC = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_END_NAME = 2'd2,
    KIND_END_PAIR = 2'd3
  } kind_e;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== sv/url_query_string_decoder_top.sv =====
// Top level of the query string decoder: parser state, decode logic and result queue.
//
//   channel  direction  handshake               payload
//   input    in         in_valid_i / in_stall_o  cmd_i, in_byte_i
//   output   out        out_valid_o / out_stall_i entry_kind_o, out_byte_o, last_o
//
// Each transfer is decoded in the cycle it is accepted; its zero to two results enter
// a three-entry result queue and appear on the output from the next cycle on.
// One input transfer per cycle is taken while the queue keeps room for two results,
// so a byte stream runs at one byte per cycle; items with two results can fill the
// queue and then stall the input even when the output drains one result per cycle.
// Reset returns the parser to the start of a parameter and empties the queue.
// A stall on the output backs up into in_stall_o once the queue is nearly full.
module url_query_string_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] entry_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam int unsigned Depth = 3;

  uqsd_pkg::phase_e  phase_q, phase_d;
  logic              hex_cnt_q, hex_cnt_d;
  logic [3:0]        hex_acc_q, hex_acc_d;
  logic              key_seen_q, key_seen_d;

  uqsd_pkg::result_t q_q [Depth];
  uqsd_pkg::result_t q_d [Depth];
  logic [1:0]        cnt_q, cnt_d;

  uqsd_pkg::result_t res [2];
  logic [1:0]        n_res;

  logic              pop, accept;
  logic [1:0]        base;

  assign out_valid_o  = (cnt_q != 2'd0);
  assign entry_kind_o = q_q[0].kind;
  assign out_byte_o   = q_q[0].data;
  assign last_o       = q_q[0].last;

  assign pop        = out_valid_o && !out_stall_i;
  assign base       = cnt_q - {1'b0, pop};
  assign in_stall_o = (base > 2'd1);
  assign accept     = in_valid_i && !in_stall_o;

  // Decode of one transfer: an escape may be flushed first, then the character is
  // handled as plain text in the phase that the flush leaves.
  always_comb begin
    uqsd_pkg::phase_e ph;
    logic             ks;
    logic             cnt;
    logic [3:0]       acc;
    logic [1:0]       n;
    logic             do_plain;
    logic             do_flush;
    logic [7:0]       fbyte;
    logic [7:0]       dec;
    logic             was_key;
    uqsd_pkg::hex_t   h;

    ph       = phase_q;
    ks       = key_seen_q;
    cnt      = hex_cnt_q;
    acc      = hex_acc_q;
    n        = 2'd0;
    do_plain = 1'b0;
    do_flush = 1'b0;
    fbyte    = (hex_cnt_q == 1'b0) ? uqsd_pkg::CH_PERCENT : {4'd0, hex_acc_q};
    was_key  = (phase_q == uqsd_pkg::PH_KEYESC);
    h        = uqsd_pkg::hex_decode(in_byte_i);
    dec      = (in_byte_i == uqsd_pkg::CH_PLUS) ? uqsd_pkg::CH_SPACE : in_byte_i;
    for (int i = 0; i < 2; i++) begin
      res[i].kind = uqsd_pkg::KIND_KEY;
      res[i].data = 8'd0;
      res[i].last = 1'b0;
    end

    if (phase_q == uqsd_pkg::PH_KEYESC || phase_q == uqsd_pkg::PH_VALESC) begin
      if (cmd_i == uqsd_pkg::CMD_FINISH) begin
        do_flush = 1'b1;
      end else if (h.valid) begin
        if (hex_cnt_q == 1'b1) begin
          do_flush = 1'b1;
          fbyte    = {hex_acc_q, h.value};
        end else begin
          cnt = 1'b1;
          acc = h.value;
        end
      end else begin
        do_flush = 1'b1;
        do_plain = 1'b1;
      end
    end else if (cmd_i == uqsd_pkg::CMD_DATA) begin
      do_plain = 1'b1;
    end

    if (do_flush) begin
      res[0].data = fbyte;
      if (was_key) begin
        res[0].kind = uqsd_pkg::KIND_KEY;
        ks          = 1'b1;
        ph          = uqsd_pkg::PH_KEY;
      end else begin
        res[0].kind = uqsd_pkg::KIND_VALUE;
        ph          = uqsd_pkg::PH_VALUE;
      end
      n   = 2'd1;
      cnt = 1'b0;
      acc = 4'd0;
    end

    if (cmd_i == uqsd_pkg::CMD_FINISH) begin
      if (do_flush) begin
        res[1].kind = was_key ? uqsd_pkg::KIND_END_NAME : uqsd_pkg::KIND_END_PAIR;
        n           = 2'd2;
      end else if (phase_q == uqsd_pkg::PH_KEY) begin
        if (key_seen_q) begin
          res[0].kind = uqsd_pkg::KIND_END_NAME;
          n           = 2'd1;
        end
      end else if (phase_q == uqsd_pkg::PH_VALUE) begin
        res[0].kind = uqsd_pkg::KIND_END_PAIR;
        n           = 2'd1;
      end
      ph  = uqsd_pkg::PH_START;
      ks  = 1'b0;
      cnt = 1'b0;
      acc = 4'd0;
    end else if (do_plain) begin
      case (ph)
        uqsd_pkg::PH_VALUE: begin
          if (in_byte_i == uqsd_pkg::CH_PERCENT) begin
            ph = uqsd_pkg::PH_VALESC;
          end else if (in_byte_i == uqsd_pkg::CH_AMP) begin
            res[n[0]].kind = uqsd_pkg::KIND_END_PAIR;
            n              = n + 2'd1;
            ph             = uqsd_pkg::PH_START;
            ks             = 1'b0;
          end else begin
            res[n[0]].kind = uqsd_pkg::KIND_VALUE;
            res[n[0]].data = dec;
            n              = n + 2'd1;
          end
        end
        uqsd_pkg::PH_KEY: begin
          if (in_byte_i == uqsd_pkg::CH_EQUALS) begin
            ph = uqsd_pkg::PH_VALUE;
          end else if (in_byte_i == uqsd_pkg::CH_AMP) begin
            res[n[0]].kind = uqsd_pkg::KIND_END_NAME;
            n              = n + 2'd1;
            ph             = uqsd_pkg::PH_START;
            ks             = 1'b0;
          end else if (in_byte_i == uqsd_pkg::CH_PERCENT) begin
            ph = uqsd_pkg::PH_KEYESC;
          end else begin
            res[n[0]].kind = uqsd_pkg::KIND_KEY;
            res[n[0]].data = dec;
            n              = n + 2'd1;
            ks             = 1'b1;
          end
        end
        default: begin
          // Start of a parameter; unused phase codes land here as well.
          ph = uqsd_pkg::PH_START;
          if (in_byte_i == uqsd_pkg::CH_EQUALS) begin
            ph = uqsd_pkg::PH_VALUE;
          end else if (in_byte_i == uqsd_pkg::CH_AMP) begin
            ph = uqsd_pkg::PH_START;
          end else if (in_byte_i == uqsd_pkg::CH_PERCENT) begin
            ph = uqsd_pkg::PH_KEYESC;
          end else begin
            res[n[0]].kind = uqsd_pkg::KIND_KEY;
            res[n[0]].data = dec;
            n              = n + 2'd1;
            ks             = 1'b1;
            ph             = uqsd_pkg::PH_KEY;
          end
        end
      endcase
    end

    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end

    n_res      = n;
    phase_d    = ph;
    key_seen_d = ks;
    hex_cnt_d  = cnt;
    hex_acc_d  = acc;
  end

  // Result queue: the head sits in entry zero and a transfer out shifts the rest down.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        q_d[i] = q_q[i + 1];
      end else begin
        q_d[i] = q_q[i];
      end
    end
    cnt_d = base;
    if (accept) begin
      if (n_res != 2'd0) begin
        q_d[base] = res[0];
      end
      if (n_res == 2'd2) begin
        q_d[base + 2'd1] = res[1];
      end
      cnt_d = base + n_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= uqsd_pkg::PH_START;
      key_seen_q <= 1'b0;
      hex_cnt_q  <= 1'b0;
      hex_acc_q  <= 4'd0;
      cnt_q      <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        phase_q    <= phase_d;
        key_seen_q <= key_seen_d;
        hex_cnt_q  <= hex_cnt_d;
        hex_acc_q  <= hex_acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the URL query string decoder, with its scoreboard and drivers.
`timescale 1ns / 100ps

import uqsd_pkg::*;

class query_scoreboard;
  phase_e     phase;
  logic [1:0] digits;
  logic [7:0] acc;
  logic       key_seen;
  result_t    expected_entries[$];
  int         errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    phase    = PH_START;
    digits   = '0;
    acc      = '0;
    key_seen = 1'b0;
  endfunction

  function int pending();
    return expected_entries.size();
  endfunction

  function void push_entry(kind_e kind, logic [7:0] data);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    expected_entries.push_back(r);
    if (kind == KIND_KEY) key_seen = 1'b1;
  endfunction

  function int hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // Emits the escaped byte, or a literal percent sign when no digit came.
  function void flush_escape();
    logic [7:0] b;
    b = (digits == 2'd0) ? CH_PERCENT : acc;
    if (phase == PH_KEYESC) begin
      push_entry(KIND_KEY, b);
      phase = PH_KEY;
    end else begin
      push_entry(KIND_VALUE, b);
      phase = PH_VALUE;
    end
    digits = '0;
    acc    = '0;
  endfunction

  function void plain_char(logic [7:0] c);
    logic [7:0] dec;
    dec = (c == CH_PLUS) ? CH_SPACE : c;
    case (phase)
      PH_VALUE: begin
        if (c == CH_PERCENT) begin
          phase = PH_VALESC;
        end else if (c == CH_AMP) begin
          push_entry(KIND_END_PAIR, 8'h00);
          phase    = PH_START;
          key_seen = 1'b0;
        end else begin
          push_entry(KIND_VALUE, dec);
        end
      end
      PH_KEY: begin
        if (c == CH_EQUALS) begin
          phase = PH_VALUE;
        end else if (c == CH_AMP) begin
          push_entry(KIND_END_NAME, 8'h00);
          phase    = PH_START;
          key_seen = 1'b0;
        end else if (c == CH_PERCENT) begin
          phase = PH_KEYESC;
        end else begin
          push_entry(KIND_KEY, dec);
        end
      end
      default: begin
        phase = PH_START;
        if (c == CH_EQUALS) begin
          phase = PH_VALUE;
        end else if (c == CH_PERCENT) begin
          phase = PH_KEYESC;
        end else if (c != CH_AMP) begin
          push_entry(KIND_KEY, dec);
          phase = PH_KEY;
        end
      end
    endcase
  endfunction

  // Predicts the results of one accepted input transfer.
  function void take_transfer(logic cmd, logic [7:0] c);
    int      prior_count;
    int      h;
    logic    esc;
    logic    was_key;
    result_t r;
    prior_count = expected_entries.size();
    esc         = (phase == PH_KEYESC) || (phase == PH_VALESC);
    if (cmd == CMD_FINISH) begin
      if (esc) begin
        was_key = (phase == PH_KEYESC);
        flush_escape();
        push_entry(was_key ? KIND_END_NAME : KIND_END_PAIR, 8'h00);
      end else if (phase == PH_KEY) begin
        if (key_seen) push_entry(KIND_END_NAME, 8'h00);
      end else if (phase == PH_VALUE) begin
        push_entry(KIND_END_PAIR, 8'h00);
      end
      restart();
    end else if (esc) begin
      h = hex_nibble(c);
      if (h >= 0) begin
        acc    = {acc[3:0], 4'(h)};
        digits = digits + 2'd1;
        if (digits >= 2'd2) flush_escape();
      end else begin
        flush_escape();
        plain_char(c);
      end
    end else begin
      plain_char(c);
    end
    if (expected_entries.size() > prior_count) begin
      r = expected_entries.pop_back();
      r.last = 1'b1;
      expected_entries.push_back(r);
    end
  endfunction

  function void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  function void check_entry(logic [1:0] kind, logic [7:0] data, logic last);
    result_t e;
    if (expected_entries.size() == 0) begin
      note_error($sformatf("unexpected result kind %0d byte %h last %0d", kind, data, last));
      return;
    end
    e = expected_entries.pop_front();
    if (kind !== e.kind || data !== e.data || last !== e.last) begin
      note_error($sformatf("expected kind %0d byte %h last %0d, got kind %0d byte %h last %0d",
                           e.kind, e.data, e.last, kind, data, last));
    end
  endfunction
endclass

module tb_top;
  localparam int ITEM_TARGET = 950;
  localparam int CYCLE_LIMIT = 700000;
  localparam int DRAIN       = 16;

  typedef struct {
    logic       cmd;
    logic [7:0] ch;
  } item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic       cmd       = CMD_DATA;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] entry_kind;
  logic [7:0] out_byte;
  logic       last;

  query_scoreboard sb;
  item_t           stream[$];
  int              sent        = 0;
  int              stall_left  = 0;
  int              cycle_count = 0;
  bit              calm        = 1'b0;

  url_query_string_decoder_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .entry_kind_o (entry_kind),
    .out_byte_o   (out_byte),
    .last_o       (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Output side: random stall runs, none while calm.
  always @(negedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_entry(entry_kind, out_byte, last);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add(logic c, logic [7:0] b);
    item_t it;
    it.cmd = c;
    it.ch  = b;
    stream.push_back(it);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    if ($urandom_range(0, 1) == 0) return 8'h41 + 8'(n) - 8'd10;
    return 8'h61 + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(8'h61, 8'h7a));
      1: return 8'($urandom_range(8'h41, 8'h5a));
      default: return 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  function automatic void add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      add(CMD_DATA, name_char());
    end else if (r < 60) begin
      add(CMD_DATA, CH_PLUS);
    end else if (r < 72) begin
      add(CMD_DATA, CH_PERCENT);
      add(CMD_DATA, hex_char(4'($urandom)));
      add(CMD_DATA, hex_char(4'($urandom)));
    end else if (r < 78) begin
      // A single digit escape; whatever follows decides how it ends.
      add(CMD_DATA, CH_PERCENT);
      add(CMD_DATA, hex_char(4'($urandom)));
    end else if (r < 82) begin
      add(CMD_DATA, CH_PERCENT);
    end else if (r < 87) begin
      add(CMD_DATA, CH_EQUALS);
    end else if (r < 95) begin
      add(CMD_DATA, 8'($urandom));
    end else begin
      add(CMD_DATA, CH_AMP);
    end
  endfunction

  function automatic void add_param();
    int n;
    n = $urandom_range(0, 4);
    repeat (n) add_token();
    if ($urandom_range(0, 4) != 0) begin
      add(CMD_DATA, CH_EQUALS);
      n = $urandom_range(0, 5);
      repeat (n) add_token();
    end
    if ($urandom_range(0, 9) == 0) add(CMD_FINISH, 8'($urandom));
    else add(CMD_DATA, CH_AMP);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_transfer(input logic c, input logic [7:0] b);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    in_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    sb.take_transfer(c, b);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_stream();
    item_t it;
    while (stream.size() != 0) begin
      it = stream.pop_front();
      send_transfer(it.cmd, it.ch);
    end
  endtask

  initial begin
    int  params;
    bit  paused_once;
    sb          = new();
    params      = 0;
    paused_once = 1'b0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Finish at parameter start, ampersand at start, equals at start.
    add(CMD_FINISH, 8'hFF);
    add(CMD_DATA, CH_AMP);
    add(CMD_DATA, CH_EQUALS);
    add(CMD_DATA, CH_AMP);
    // Extreme bytes in a name, a two digit escape, a bare percent before a plus.
    add(CMD_DATA, 8'h00);
    add(CMD_DATA, 8'hFF);
    add(CMD_DATA, CH_PERCENT);
    add(CMD_DATA, 8'h34);
    add(CMD_DATA, 8'h31);
    add(CMD_DATA, CH_PERCENT);
    add(CMD_DATA, CH_PLUS);
    // One digit escape in a value, ended by an ampersand.
    add(CMD_DATA, CH_EQUALS);
    add(CMD_DATA, CH_PERCENT);
    add(CMD_DATA, 8'h61);
    add(CMD_DATA, CH_AMP);
    // Finish inside a name escape with no digit.
    add(CMD_DATA, CH_PERCENT);
    add(CMD_FINISH, 8'h00);
    // Equals inside a value, then finish inside a value escape.
    add(CMD_DATA, 8'h62);
    add(CMD_DATA, CH_EQUALS);
    add(CMD_DATA, CH_EQUALS);
    add(CMD_DATA, CH_PERCENT);
    add(CMD_DATA, 8'h46);
    add(CMD_FINISH, 8'h5A);
    // Finish with an empty value.
    add(CMD_DATA, 8'h76);
    add(CMD_DATA, CH_EQUALS);
    add(CMD_FINISH, 8'h00);
    send_stream();

    while (sent < ITEM_TARGET) begin
      if (params % 12 == 0) calm = ($urandom_range(0, 3) == 0);
      params++;
      if ($urandom_range(0, 19) == 0) begin
        // Pure noise, including random finish transfers.
        repeat ($urandom_range(1, 6)) add(1'($urandom), 8'($urandom));
      end else begin
        add_param();
      end
      send_stream();
      if (!paused_once && sent >= ITEM_TARGET / 2) begin
        paused_once = 1'b1;
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
    end

    calm = 1'b1;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
